@@ hdl/cal_pkg.sv @@
package cal_pkg;

    localparam int GRID_SIZE_DEF = 256;
    localparam int WORD_BITS_DEF = 64;

    localparam int ROW_IDX_W  = 8;
    localparam int WORD_IDX_W = 2;
    localparam int DATA_W     = 64;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic [1:0] {
        RULE_LIFE   = 2'd0,
        RULE_VOTE   = 2'd1,
        RULE_ANNEAL = 2'd2,
        RULE_COPY   = 2'd3
    } t_rule_mode;

    typedef struct packed {
        logic                  func;
        logic [ROW_IDX_W-1:0]  load_row;
        logic [WORD_IDX_W-1:0] load_word;
        logic [DATA_W-1:0]     load_data;
    } t_in_word;

    typedef struct packed {
        logic [ROW_IDX_W-1:0]  row_index;
        logic [WORD_IDX_W-1:0] word_index;
        logic [DATA_W-1:0]     new_cells;
        logic                  last;
    } t_out_word;

endpackage

@@ hdl/cal_ram.sv @@
module cal_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cal_word_unit.sv @@
module cal_word_unit import cal_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  t_rule_mode           i_mode,
    input  logic [WORD_BITS-1:0] i_up_prev,
    input  logic [WORD_BITS-1:0] i_up_cur,
    input  logic [WORD_BITS-1:0] i_up_next,
    input  logic [WORD_BITS-1:0] i_mid_prev,
    input  logic [WORD_BITS-1:0] i_mid_cur,
    input  logic [WORD_BITS-1:0] i_mid_next,
    input  logic [WORD_BITS-1:0] i_dn_prev,
    input  logic [WORD_BITS-1:0] i_dn_cur,
    input  logic [WORD_BITS-1:0] i_dn_next,
    output logic [WORD_BITS-1:0] o_cells
);

    logic [WORD_BITS-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic [WORD_BITS-1:0] h0, l0, h1, l1, h2, l2, c, c2, s0, s1, s2;
    logic [WORD_BITS-1:0] a0, a1, a2, a3, t0, t1, x, y, z;

    // left neighbor moves up one column, right neighbor down one
    assign up_l  = {i_up_cur[WORD_BITS-2:0],  i_up_prev[WORD_BITS-1]};
    assign up_r  = {i_up_next[0],  i_up_cur[WORD_BITS-1:1]};
    assign mid_l = {i_mid_cur[WORD_BITS-2:0], i_mid_prev[WORD_BITS-1]};
    assign mid_r = {i_mid_next[0], i_mid_cur[WORD_BITS-1:1]};
    assign dn_l  = {i_dn_cur[WORD_BITS-2:0],  i_dn_prev[WORD_BITS-1]};
    assign dn_r  = {i_dn_next[0],  i_dn_cur[WORD_BITS-1:1]};

    always_comb begin
        // per-row partial counts
        t0 = up_l ^ up_r;
        l0 = t0 ^ i_up_cur;
        h0 = (up_l & up_r) | (t0 & i_up_cur);
        l1 = mid_l ^ mid_r;
        h1 = mid_l & mid_r;
        t1 = dn_l ^ dn_r;
        l2 = t1 ^ i_dn_cur;
        h2 = (dn_l & dn_r) | (t1 & i_dn_cur);

        // combine into the bitsliced neighbor count
        s0 = l0 ^ l1;
        c  = l0 & l1;
        s1 = (h0 ^ h1) ^ c;
        s2 = (h0 & h1) | ((h0 ^ h1) & c);
        a0 = s0 ^ l2;
        c  = s0 & l2;
        a1 = (s1 ^ h2) ^ c;
        c2 = (s1 & h2) | ((s1 ^ h2) & c);
        a2 = s2 ^ c2;
        a3 = s2 & c2;

        x = '0;
        y = '0;
        z = '0;
        unique case (i_mode)
            RULE_LIFE: begin
                o_cells = (a0 | i_mid_cur) & ~a3 & a1 & ~a2;
            end
            RULE_VOTE: begin
                x       = (i_mid_cur & a2) | a1 | a0;
                o_cells = (a2 ^ a3) & ~(x ^ a2);
            end
            RULE_ANNEAL: begin
                x       = ((a0 ^ i_mid_cur) | a3) ^ a1;
                y       = (a0 | a2) & x;
                z       = ((a2 ^ a1) | a3) & ~y;
                o_cells = z ^ a1;
            end
            RULE_COPY: begin
                o_cells = i_up_cur;
            end
            default: begin
                o_cells = '0;
            end
        endcase
    end

endmodule

@@ hdl/cellular_automaton_line_updater_core.sv @@
// Line updater for a square life-like cell grid held in an internal RAM.
// Input channel (i_in_valid / o_in_stall, i_in_data): a load word writes one
// grid word and is done in the accepting cycle; out-of-range loads are dropped.
// A step word updates the row under the internal row pointer in place and
// sends one output word per grid word of that row, the last one marked.
// Output channel (o_out_valid / i_out_stall, o_out_data) is a single output
// register; a new word is taken there as soon as the old one leaves.
// Rule mode is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Sequence: a step keeps the input stalled until its last output word is
// registered. Every word needs a grid read of its own row, a grid read of
// the row below, a window shift and an emit, all through the single read
// port of the grid RAM. The first word's pass has no emit; each later pass
// emits the word before it.
// A stalled output holds the sequencer in its emit step until the word leaves.
// Reset clears the row pointer, rule mode (Life) and output valid; the grid
// holds no defined data until loaded.
module cellular_automaton_line_updater_core import cal_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    localparam int WPR   = GRID_SIZE / WORD_BITS;
    localparam int DEPTH = GRID_SIZE * WPR;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GRID_SIZE);
    localparam int KW    = $clog2(WPR + 1);
    localparam int XW    = (WPR > 1) ? $clog2(WPR) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_DN,
        S_SHIFT,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [KW-1:0]        r_k;
    logic [RW-1:0]        r_row;
    t_rule_mode           r_rule_mode;
    logic [WORD_BITS-1:0] r_mid_in;
    logic [WORD_BITS-1:0] r_up_p, r_up_c, r_up_n;
    logic [WORD_BITS-1:0] r_md_p, r_md_c, r_md_n;
    logic [WORD_BITS-1:0] r_dn_p, r_dn_c, r_dn_n;
    logic                 r_out_valid;
    t_out_word            r_out_data;

    logic                 w_accept, w_load_ok, w_step, w_emit;
    logic                 w_k_live, w_row_last, w_k_done;
    logic [RW-1:0]        w_nxt_row;
    logic [KW-1:0]        w_k_prev;
    logic [AW-1:0]        w_mid_addr, w_dn_addr, w_res_addr, w_load_addr;
    logic                 w_grid_we, w_grid_re;
    logic [AW-1:0]        w_grid_waddr, w_grid_raddr;
    logic [WORD_BITS-1:0] w_grid_wdata, w_grid_rdata;
    logic [WORD_BITS-1:0] w_old_rdata, w_new;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_step    = w_accept && (i_in_data.func == FUNC_STEP);
    assign w_load_ok = w_accept && (i_in_data.func == FUNC_LOAD)
                       && (int'(i_in_data.load_row) < GRID_SIZE)
                       && (int'(i_in_data.load_word) < WPR);
    assign w_emit    = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    assign w_k_live   = (r_k < KW'(WPR));
    assign w_k_done   = (r_k == KW'(WPR));
    assign w_k_prev   = r_k - KW'(1);
    assign w_row_last = (r_row == RW'(GRID_SIZE - 1));
    assign w_nxt_row  = w_row_last ? '0 : r_row + RW'(1);

    assign w_mid_addr  = AW'(r_row) * AW'(WPR) + AW'(r_k);
    assign w_dn_addr   = AW'(w_nxt_row) * AW'(WPR) + AW'(r_k);
    assign w_res_addr  = AW'(r_row) * AW'(WPR) + AW'(w_k_prev);
    assign w_load_addr = AW'(i_in_data.load_row) * AW'(WPR) + AW'(i_in_data.load_word);

    assign w_grid_we    = w_load_ok || w_emit;
    assign w_grid_waddr = w_emit ? w_res_addr : w_load_addr;
    assign w_grid_wdata = w_emit ? w_new : WORD_BITS'(i_in_data.load_data);
    assign w_grid_re    = ((r_state == S_MID) || (r_state == S_DN)) && w_k_live;
    assign w_grid_raddr = (r_state == S_MID) ? w_mid_addr : w_dn_addr;

    cal_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_grid_we),
        .i_waddr (w_grid_waddr),
        .i_wdata (w_grid_wdata),
        .i_re    (w_grid_re),
        .i_raddr (w_grid_raddr),
        .o_rdata (w_grid_rdata)
    );

    // pre-update copy of the row above; written as each word of the row is read
    cal_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WPR)
    ) u_old_row (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_DN) && w_k_live),
        .i_waddr (XW'(r_k)),
        .i_wdata (w_grid_rdata),
        .i_re    ((r_state == S_MID) && w_k_live),
        .i_raddr (XW'(r_k)),
        .o_rdata (w_old_rdata)
    );

    cal_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_unit (
        .i_mode     (r_rule_mode),
        .i_up_prev  (r_up_p),
        .i_up_cur   (r_up_c),
        .i_up_next  (r_up_n),
        .i_mid_prev (r_md_p),
        .i_mid_cur  (r_md_c),
        .i_mid_next (r_md_n),
        .i_dn_prev  (r_dn_p),
        .i_dn_cur   (r_dn_c),
        .i_dn_next  (r_dn_n),
        .o_cells    (w_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_row       <= '0;
            r_rule_mode <= RULE_LIFE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rule_mode <= t_rule_mode'(i_cfg_wdata);
            end
            if (r_out_valid && !i_out_stall && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_step) begin
                        r_k     <= '0;
                        r_state <= S_MID;
                        r_up_p  <= '0;
                        r_up_c  <= '0;
                        r_up_n  <= '0;
                        r_md_p  <= '0;
                        r_md_c  <= '0;
                        r_md_n  <= '0;
                        r_dn_p  <= '0;
                        r_dn_c  <= '0;
                        r_dn_n  <= '0;
                    end
                end
                S_MID: begin
                    r_state <= S_DN;
                end
                S_DN: begin
                    r_mid_in <= w_grid_rdata;
                    r_state  <= S_SHIFT;
                end
                S_SHIFT: begin
                    // advance the three-word windows; beyond the grid reads as zero
                    r_up_p <= r_up_c;
                    r_up_c <= r_up_n;
                    r_up_n <= (w_k_live && (r_row != '0)) ? w_old_rdata : '0;
                    r_md_p <= r_md_c;
                    r_md_c <= r_md_n;
                    r_md_n <= w_k_live ? r_mid_in : '0;
                    r_dn_p <= r_dn_c;
                    r_dn_c <= r_dn_n;
                    r_dn_n <= (w_k_live && !w_row_last) ? w_grid_rdata : '0;
                    if (r_k == '0) begin
                        r_k     <= KW'(1);
                        r_state <= S_MID;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_valid           <= 1'b1;
                        r_out_data.row_index  <= ROW_IDX_W'(r_row);
                        r_out_data.word_index <= WORD_IDX_W'(w_k_prev);
                        r_out_data.new_cells  <= DATA_W'(w_new);
                        r_out_data.last       <= w_k_done;
                        if (w_k_done) begin
                            r_row   <= w_nxt_row;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_MID;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/cal_checker.sv @@
module cal_checker import cal_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // an accepted step keeps the input stalled in the next cycle
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.func == FUNC_STEP) |=> o_in_stall)
        else $error("input not stalled after a step word");

    // more words of the row are still to come, so no new input is taken
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_in_stall)
        else $error("input open in the middle of a row");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind cellular_automaton_line_updater_core cal_checker u_cal_checker (.*);
